### hw/rtl/assert_macros.svh
// Assertion macros shared by the sensor status frame builder RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/ssfb_pkg.sv
// Shared types, codes and width helpers for the sensor status frame builder.
// No dependencies.
`timescale 1ns / 1ps

package ssfb_pkg;

  localparam int ECHO_COUNT_WIDTH_DEF = 16;
  localparam int TEMP_W = 10;
  localparam int THR_W  = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_DIST_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_GAIN      = 2'd2;

  localparam logic [THR_W-1:0]  THR_RESET    = 14'd50;
  localparam logic [TEMP_W-1:0] OFFSET_RESET = 10'd673;
  localparam logic [TEMP_W-1:0] GAIN_RESET   = 10'd423;

  localparam logic [7:0] CHAR_HEAD  = 8'h69;  // 'i'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_SEP   = 8'h24;  // '$'
  localparam logic [7:0] CHAR_TAIL  = 8'h23;  // '#'

  typedef logic [2:0] bsel_t;
  localparam bsel_t BSEL_HEAD  = 3'd0;
  localparam bsel_t BSEL_MINUS = 3'd1;
  localparam bsel_t BSEL_DIGIT = 3'd2;
  localparam bsel_t BSEL_SEP   = 3'd3;
  localparam bsel_t BSEL_TAIL  = 3'd4;

  typedef logic [1:0] nsel_t;
  localparam nsel_t NUM_DIST  = 2'd0;
  localparam nsel_t NUM_TEMP  = 2'd1;
  localparam nsel_t NUM_CHECK = 2'd2;

  typedef struct packed {
    logic  load;
    logic  div_step;
    logic  tmul;
    logic  temp_calc;
    logic  chk_calc;
    logic  conv_load;
    logic  conv_step;
    logic  lead;
    logic  emit;
    bsel_t bsel;
    nsel_t num_sel;
  } ssfb_cmd_t;

  typedef struct packed {
    logic out_free;
    logic neg;
    logic idx_zero;
  } ssfb_sts_t;

  function automatic int dist_w(input int w);
    return w - 1;
  endfunction

  // dist = ((count * 100) / 58) / 10 = (count * 5) / 29
  // = (count * dist_recip(w)) >> (w + 5), exact for any w-bit count
  function automatic longint unsigned dist_recip(input int w);
    return ((longint'(5) << (w + 5)) + 28) / 29;
  endfunction

  function automatic int mag_w(input int w);
    return (w > 12) ? w : 12;
  endfunction

  function automatic int in_tdata_w(input int w);
    return ((w + TEMP_W + 7) / 8) * 8;
  endfunction

  function automatic int dec_digits(input int bits);
    longint unsigned v;
    int n;
    v = 64'(1) << bits;
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 0) begin
        v = v / 10;
        n++;
      end
    end
    return n;
  endfunction

endpackage

### hw/rtl/ssfb_ctrl.sv
// Sequencer for the frame builder: divide, temperature, conversions, byte issue.
// Depends on ssfb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssfb_ctrl
  import ssfb_pkg::*;
#(
  parameter int ECHO_COUNT_WIDTH = ECHO_COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output ssfb_cmd_t cmd,
  input  ssfb_sts_t sts
);

  localparam int MAG_W = mag_w(ECHO_COUNT_WIDTH);
  localparam int CNT_W = $clog2(MAG_W);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_TMUL  = 4'd2;
  localparam logic [3:0] S_TEMP  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_HEAD  = 4'd5;
  localparam logic [3:0] S_CLOAD = 4'd6;
  localparam logic [3:0] S_CONV  = 4'd7;
  localparam logic [3:0] S_LEAD  = 4'd8;
  localparam logic [3:0] S_SIGN  = 4'd9;
  localparam logic [3:0] S_DIG   = 4'd10;
  localparam logic [3:0] S_SEP   = 4'd11;
  localparam logic [3:0] S_TAIL  = 4'd12;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  nsel_t            num_sel_r, num_sel_nxt;

  assign in_tready = rst_n && (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    num_sel_nxt = num_sel_r;
    cmd         = '0;
    cmd.num_sel = num_sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_TMUL;
      end
      S_TMUL: begin
        cmd.tmul  = 1'b1;
        state_nxt = S_TEMP;
      end
      S_TEMP: begin
        cmd.temp_calc = 1'b1;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        cmd.chk_calc = 1'b1;
        state_nxt    = S_HEAD;
      end
      S_HEAD: begin
        cmd.bsel = BSEL_HEAD;
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          num_sel_nxt = NUM_DIST;
          state_nxt   = S_CLOAD;
        end
      end
      S_CLOAD: begin
        cmd.conv_load = 1'b1;
        cnt_nxt       = CNT_W'(MAG_W - 1);
        state_nxt     = S_CONV;
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_LEAD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_LEAD: begin
        cmd.lead  = 1'b1;
        state_nxt = S_SIGN;
      end
      S_SIGN: begin
        cmd.bsel = BSEL_MINUS;
        if (!sts.neg) begin
          state_nxt = S_DIG;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        cmd.bsel = BSEL_DIGIT;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = S_SEP;
          end
        end
      end
      S_SEP: begin
        cmd.bsel = BSEL_SEP;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (num_sel_r == NUM_CHECK) begin
            state_nxt = S_TAIL;
          end else begin
            num_sel_nxt = num_sel_r + 1'b1;
            state_nxt   = S_CLOAD;
          end
        end
      end
      S_TAIL: begin
        cmd.bsel = BSEL_TAIL;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      num_sel_r <= NUM_DIST;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      num_sel_r <= num_sel_nxt;
    end
  end

  `ASSERT_RST(a_accept_starts_div, clk, rst_n,
    (in_tvalid && in_tready) |=> (state_r == S_DIV), "accepted transaction did not start divide")
  `ASSERT_RST(a_emit_needs_slot, clk, rst_n,
    cmd.emit |-> sts.out_free, "byte issued into an occupied output register")
  `ASSERT_RST(a_num_sel_range, clk, rst_n,
    num_sel_r != 2'd3, "number select out of range")
  `ASSERT_RST(a_last_digit_to_sep, clk, rst_n,
    (state_r == S_DIG && sts.out_free && sts.idx_zero) |=> (state_r == S_SEP),
    "separator did not follow the last digit")
  `ASSERT_RST(a_tail_to_idle, clk, rst_n,
    (state_r == S_TAIL && sts.out_free) |=> in_tready, "frame end did not return to idle")

endmodule

### hw/rtl/ssfb_dp.sv
// Datapath: config registers, reciprocal divide-by-29 unit, temperature math,
// binary to BCD converter and the output byte register. Depends on ssfb_pkg.
`timescale 1ns / 1ps

module ssfb_dp
  import ssfb_pkg::*;
#(
  parameter int ECHO_COUNT_WIDTH = ECHO_COUNT_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_valid,
  input  logic [CFG_IDX_W-1:0]                      cfg_index,
  input  logic [CFG_DATA_W-1:0]                     cfg_data,
  input  logic [in_tdata_w(ECHO_COUNT_WIDTH)-1:0]   in_tdata,
  input  ssfb_cmd_t                                 cmd,
  output ssfb_sts_t                                 sts,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [7:0]                                out_tdata,
  output logic                                      out_tlast,
  output logic                                      out_tuser
);

  localparam int W        = ECHO_COUNT_WIDTH;
  localparam int DIST_W   = dist_w(W);
  localparam int RECIP_W  = W + 3;
  localparam int RECIP_SH = W + 5;
  localparam int PROD_W   = W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(dist_recip(W));
  localparam int MAG_W    = mag_w(W);
  localparam int CHK_W    = MAG_W + 1;
  localparam int NDIG     = dec_digits(MAG_W);
  localparam int IDX_W    = $clog2(NDIG);
  localparam int CMP_W    = (DIST_W > THR_W) ? DIST_W : THR_W;

  logic [THR_W-1:0]        thr_r;
  logic [TEMP_W-1:0]       off_r, gain_r;

  logic [W-1:0]            count_r;
  logic [DIST_W-1:0]       dist_r;
  logic signed [10:0]      diff_r;
  logic signed [21:0]      prod_r;
  logic signed [10:0]      temp_r;
  logic signed [CHK_W-1:0] check_r;
  logic                    water_r;
  logic                    neg_r;
  logic [MAG_W-1:0]        mag_r;
  logic [4*NDIG-1:0]       bcd_r;
  logic [IDX_W-1:0]        idx_r;

  logic [7:0]              out_byte_r;
  logic                    out_last_r, out_water_r, out_tvalid_r;

  logic [W-1:0]            count;
  logic [TEMP_W-1:0]       sample;
  logic [PROD_W-1:0]       dist_prod;
  logic signed [21:0]      prod_adj;
  logic signed [CHK_W-1:0] dist_ext, temp_ext, conv_val, conv_neg;
  logic [4*NDIG-1:0]       bcd_adj;
  logic [IDX_W-1:0]        lead_idx;
  logic [3:0]              cur_digit;
  logic [7:0]              byte_nxt;

  assign count     = in_tdata[W-1:0];
  assign sample    = in_tdata[W+TEMP_W-1:W];
  assign dist_prod = PROD_W'(count_r) * PROD_W'(RECIP);
  assign prod_adj  = prod_r + (prod_r[21] ? 22'sd1023 : 22'sd0);
  assign dist_ext  = $signed({{(CHK_W-DIST_W){1'b0}}, dist_r});
  assign temp_ext  = $signed({{(CHK_W-11){temp_r[10]}}, temp_r});
  assign conv_neg  = -conv_val;
  assign cur_digit = bcd_r[4*idx_r +: 4];

  always_comb begin
    case (cmd.num_sel)
      NUM_DIST: conv_val = dist_ext;
      NUM_TEMP: conv_val = temp_ext;
      default:  conv_val = check_r;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        lead_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    case (cmd.bsel)
      BSEL_HEAD:  byte_nxt = CHAR_HEAD;
      BSEL_MINUS: byte_nxt = CHAR_MINUS;
      BSEL_DIGIT: byte_nxt = CHAR_ZERO + {4'd0, cur_digit};
      BSEL_SEP:   byte_nxt = CHAR_SEP;
      default:    byte_nxt = CHAR_TAIL;
    endcase
  end

  assign sts.out_free = !out_tvalid_r || out_tready;
  assign sts.neg      = neg_r;
  assign sts.idx_zero = (idx_r == '0);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      off_r  <= OFFSET_RESET;
      gain_r <= GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIST_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        CFG_TEMP_OFFSET:    off_r  <= cfg_data[TEMP_W-1:0];
        CFG_TEMP_GAIN:      gain_r <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // arithmetic payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count_r <= count;
      diff_r  <= $signed({1'b0, sample}) - $signed({1'b0, off_r});
    end
    if (cmd.div_step) begin
      dist_r <= DIST_W'(dist_prod >> RECIP_SH);
    end
    if (cmd.tmul) begin
      prod_r <= diff_r * $signed({1'b0, gain_r});
    end
    if (cmd.temp_calc) begin
      temp_r <= prod_adj[20:10];
    end
    if (cmd.chk_calc) begin
      check_r <= dist_ext + temp_ext;
      water_r <= CMP_W'(dist_r) > CMP_W'(thr_r);
    end
    if (cmd.conv_load) begin
      neg_r <= conv_val[CHK_W-1];
      mag_r <= conv_val[CHK_W-1] ? conv_neg[MAG_W-1:0] : conv_val[MAG_W-1:0];
      bcd_r <= '0;
    end else if (cmd.conv_step) begin
      bcd_r <= {bcd_adj[4*NDIG-2:0], mag_r[MAG_W-1]};
      mag_r <= {mag_r[MAG_W-2:0], 1'b0};
    end
    if (cmd.lead) begin
      idx_r <= lead_idx;
    end else if (cmd.emit && cmd.bsel == BSEL_DIGIT) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r  <= byte_nxt;
      out_last_r  <= (cmd.bsel == BSEL_TAIL);
      out_water_r <= water_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_water_r;

endmodule

### hw/rtl/sensor_status_frame_builder_core.sv
// Sequence: after the accepting edge the core does the reciprocal divide by 29, the
// temperature multiply and scale and the check sum, then presents the 'i' head byte.
// Each number is then converted to BCD over max(ECHO_COUNT_WIDTH,12) bits and issued as
// bytes plus '$'. One transaction at a time; a low out_tready stalls the byte issue.
// Reset: synchronous, active low; registers return to threshold 50, offset 673, gain 423.
`timescale 1ns / 1ps

module sensor_status_frame_builder_core
  import ssfb_pkg::*;
#(
  parameter int ECHO_COUNT_WIDTH = ECHO_COUNT_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]                    cfg_index,
  input  logic [CFG_DATA_W-1:0]                   cfg_data,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // in_tdata: echo_count[ECHO_COUNT_WIDTH], temp_sample[10], zero fill
  input  logic [in_tdata_w(ECHO_COUNT_WIDTH)-1:0] in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // out_tdata: frame_byte[8]
  output logic [7:0]                              out_tdata,
  output logic                                    out_tlast,
  // out_tuser: need_water[1]
  output logic                                    out_tuser
);

  ssfb_cmd_t cmd;
  ssfb_sts_t sts;

  assign cfg_ready = rst_n;

  ssfb_ctrl #(
    .ECHO_COUNT_WIDTH(ECHO_COUNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ssfb_dp #(
    .ECHO_COUNT_WIDTH(ECHO_COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for sensor_status_frame_builder_core: drives measurement
// transactions, predicts each ASCII status frame and compares it byte by byte.
// Depends on ssfb_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import ssfb_pkg::*;

  localparam int IN_W = in_tdata_w(ECHO_COUNT_WIDTH_DEF);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 75;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_sample;
    logic [15:0]       echo_count;
  } sensor_sample_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       wet;
  } frame_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  // Predictor copy of the registers
  logic [THR_W-1:0]  thr_reg = THR_RESET;
  logic [TEMP_W-1:0] offset_reg = OFFSET_RESET;
  logic [TEMP_W-1:0] gain_reg = GAIN_RESET;

  sensor_sample_t pending_samples[$];
  sensor_sample_t cur_sample;
  frame_char_t    expected_chars[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  int errors = 0;
  int frames_sent = 0;
  int chars_checked = 0;
  int cfg_writes = 0;
  int neg_temp_frames = 0;
  int wet_frames = 0;
  int cycle_count = 0;

  sensor_status_frame_builder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  function automatic void append_decimal(ref logic [7:0] text[$], input longint v);
    logic [7:0] digs[$];
    longint mag;
    mag = v;
    if (v < 0) begin
      text.push_back(CHAR_MINUS);
      mag = -v;
    end
    do begin
      digs.push_front(CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (digs[i]) text.push_back(digs[i]);
  endfunction

  function automatic void build_frame(input sensor_sample_t s);
    logic [7:0] text[$];
    longint dist_cm;
    longint temp;
    longint chk;
    logic wet;
    dist_cm = (longint'(s.echo_count) * 100 / 58) / 10;
    temp = (longint'(s.temp_sample) - longint'(offset_reg)) * longint'(gain_reg) / 1024;
    chk = dist_cm + temp;
    wet = dist_cm > longint'(thr_reg);
    text.push_back(CHAR_HEAD);
    append_decimal(text, dist_cm);
    text.push_back(CHAR_SEP);
    append_decimal(text, temp);
    text.push_back(CHAR_SEP);
    append_decimal(text, chk);
    text.push_back(CHAR_SEP);
    text.push_back(CHAR_TAIL);
    foreach (text[k]) expected_chars.push_back('{text[k], k == text.size() - 1, wet});
    if (temp < 0) neg_temp_frames++;
    if (wet) wet_frames++;
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH char %0d: %s", $realtime, chars_checked, what);
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        build_frame(cur_sample);
        frames_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_sample = pending_samples.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= IN_W'(cur_sample);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    frame_char_t exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char 0x%02h", out_tdata));
      end else begin
        exp_c = expected_chars.pop_front();
        if (out_tdata !== exp_c.ch)
          flag_mismatch($sformatf("frame_byte 0x%02h, want 0x%02h", out_tdata, exp_c.ch));
        if (out_tlast !== exp_c.last)
          flag_mismatch($sformatf("frame_last %b, want %b", out_tlast, exp_c.last));
        if (out_tuser !== exp_c.wet)
          flag_mismatch($sformatf("need_water %b, want %b", out_tuser, exp_c.wet));
      end
      chars_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sensor_status_frame_builder_core verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DIST_THRESHOLD: thr_reg = val;
      CFG_TEMP_OFFSET:    offset_reg = val[TEMP_W-1:0];
      CFG_TEMP_GAIN:      gain_reg = val[TEMP_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_regs(input int thr, input int off, input int gain);
    write_reg(CFG_DIST_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_TEMP_OFFSET, CFG_DATA_W'(off));
    write_reg(CFG_TEMP_GAIN, CFG_DATA_W'(gain));
    @(negedge clk);
  endtask

  task automatic add_sample(input int c, input int t);
    pending_samples.push_back('{temp_sample: TEMP_W'(t), echo_count: 16'(c)});
  endtask

  // Sender pauses until every frame has fully arrived
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_tvalid || expected_chars.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic add_random_sample();
    int c;
    int t;
    case ($urandom_range(3))
      0: c = $urandom_range(65535);
      1: c = $urandom_range(2000);
      2: c = int'(thr_reg) * 29 / 5 + $urandom_range(12) - 6;
      default: c = $urandom_range(1) ? 0 : 65535 - $urandom_range(40);
    endcase
    case ($urandom_range(3))
      0: t = int'(offset_reg) + $urandom_range(6) - 3;
      1: t = $urandom_range(1) ? 0 : 1023;
      default: t = $urandom_range(1023);
    endcase
    if (c < 0) c = 0;
    if (c > 65535) c = 65535;
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    add_sample(c, t);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values, no idling
    add_sample(0, 0);          // negative temperature and check
    add_sample(65535, 1023);   // largest count and sample
    add_sample(65535, 0);
    add_sample(1613, 0);       // check exactly zero
    add_sample(0, 673);        // all zero, shortest frame
    add_sample(0, 672);        // small negative product truncates to zero
    add_sample(0, 671);
    add_sample(0, 670);
    add_sample(290, 700);      // distance equal to threshold
    add_sample(296, 700);      // distance one above threshold
    add_sample(57, 800);
    add_sample(58, 800);       // distance gains a digit
    add_sample(5, 1023);
    add_sample(16'hAAAA, 10'h155);
    add_sample(16'h5555, 10'h2AA);
    add_sample(1, 1);
    add_sample(6, 1);
    wait_idle();

    // Extreme registers
    set_regs(0, 0, 1023);
    add_sample(0, 1023);
    add_sample(65535, 1023);
    add_sample(0, 0);
    add_sample(1, 512);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          // upper data bits beyond register width are dropped; unused index ignored
          set_regs(14'h3FFF, 14'h3FFF, 14'h3C00);
          write_reg(CFG_NO_REG, 14'h1234);
          @(negedge clk);
          tx_idle_pct = 74;
          rx_stall_pct = 0;
        end
        2: begin
          set_regs($urandom_range(11299), $urandom_range(1023), $urandom_range(1023));
          tx_idle_pct = 0;
          rx_stall_pct = 74;
          fork
            begin
              rx_hold = 1'b1;
              repeat (RX_HOLD_CYCLES) @(negedge clk);
              rx_hold = 1'b0;
            end
          join_none
        end
        default: begin
          set_regs(THR_RESET, OFFSET_RESET, GAIN_RESET);
          tx_idle_pct = 19;
          rx_stall_pct = 19;
        end
      endcase
      repeat (RANDOM_PER_PHASE) add_random_sample();
      wait_idle();
    end

    $display("ran %0d frames, %0d chars checked, %0d register writes",
             frames_sent, chars_checked, cfg_writes);
    $display("frames with negative temperature: %0d, with need_water set: %0d",
             neg_temp_frames, wet_frames);
    if (errors == 0) begin
      $display("sensor_status_frame_builder_core verification clean");
    end else begin
      $display("sensor_status_frame_builder_core verification failed");
    end
    $finish;
  end

endmodule

### sensor_status_frame_builder_core.f
+incdir+hw/rtl
hw/rtl/ssfb_pkg.sv
hw/rtl/ssfb_ctrl.sv
hw/rtl/ssfb_dp.sv
hw/rtl/sensor_status_frame_builder_core.sv
tb/testbench.sv
